// File: rtl/brr_adpcm_voice_mixer_unit_macros.svh
// Assertion macros shared by the voice mixer RTL.
// Included by the files that carry concurrent assertions; depends on nothing.
`ifndef BRR_ADPCM_VOICE_MIXER_UNIT_MACROS_SVH
`define BRR_ADPCM_VOICE_MIXER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define BRR_AVM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define BRR_AVM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BRR_AVM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define BRR_AVM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: rtl/brr_avm_pkg.sv
// Types, register offsets and helper functions of the voice mixer.
// Used by the top level and brr_avm_store; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package brr_avm_pkg;

    localparam logic [1:0] CMD_MEM_WR = 2'd0;
    localparam logic [1:0] CMD_REG_WR = 2'd1;
    localparam logic [1:0] CMD_RENDER = 2'd2;

    localparam logic [6:0] REG_KEY_ON   = 7'h4C;
    localparam logic [6:0] REG_DIR_PAGE = 7'h5D;

    localparam logic [6:0] REG_VOL_L    = 7'h0;
    localparam logic [6:0] REG_VOL_R    = 7'h1;
    localparam logic [6:0] REG_PITCH_LO = 7'h2;
    localparam logic [6:0] REG_PITCH_HI = 7'h3;
    localparam logic [6:0] REG_SRCN     = 7'h4;

    localparam logic [14:0] PHASE_STEP = 15'h1000;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] address;
        logic [7:0]  data;
    } brr_req_t;

    typedef struct packed {
        logic signed [15:0] sample;
    } brr_rsp_t;

    typedef struct packed {
        logic        mem_we;
        logic        reg_we;
        logic [15:0] addr;
        logic [7:0]  data;
    } brr_wr_t;

    typedef struct packed {
        logic [15:0] mem_addr;
        logic [6:0]  reg_addr;
    } brr_rd_t;

    function automatic logic signed [15:0] sat16(input logic signed [19:0] x);
        logic signed [15:0] r;
        if (x < -20'sd32768)
        begin
            r = -16'sd32768;
        end
        else if (x > 20'sd32767)
        begin
            r = 16'sd32767;
        end
        else
        begin
            r = x[15:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// File: rtl/brr_avm_chan_if.sv
// Valid/ready channel carrying one word of payload type T.
// Depends on nothing; payload types come from brr_avm_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface brr_avm_chan_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// File: rtl/brr_adpcm_voice_mixer_unit.sv
// Top level of the BRR voice mixer: command sequencer, per-voice state and output word.
// Depends on brr_avm_pkg, brr_avm_chan_if, brr_avm_store, brr_avm_mul and the macro header.
//
// Usage: words arrive on req (command, address, data) and rendered samples leave on rsp.
// Writing the key-on register walks the voices and runs a directory lookup for each keyed voice.
// A render word walks every voice through one sequencer and one shared multiplier: per voice
// the register reads, a loop pass for each pitch step, the decode of each nibble by an
// active voice, a directory lookup when a block loops, and mixing; then the result is loaded.
// The sample memory port serves one read a cycle.
// req.ready is high only while the sequencer is idle. A finished sample sits in the output
// register; the next word is accepted while it waits, but a further render holds in its final
// step until rsp takes the previous sample.
// After reset a clearing pass zeroes the sample memory and sound registers;
// req.ready stays low throughout.
`timescale 1ns / 1ps
`default_nettype none
`include "brr_adpcm_voice_mixer_unit_macros.svh"
module brr_adpcm_voice_mixer_unit #(
    parameter int VOICE_COUNT = 8
) (
    input  wire            clk,
    input  wire            rst_n,
    brr_avm_chan_if.sink   req,
    brr_avm_chan_if.source rsp
);
    import brr_avm_pkg::*;

    localparam int VIDX_W = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;

    typedef enum logic [18:0] {
        S_IDLE      = 19'd1,
        S_KEY_SCAN  = 19'd2,
        S_DIR_A     = 19'd4,
        S_DIR_B     = 19'd8,
        S_DIR_C     = 19'd16,
        S_DIR_D     = 19'd32,
        S_DIR_E     = 19'd64,
        S_R_PLO     = 19'd128,
        S_R_PHI     = 19'd256,
        S_R_VL      = 19'd512,
        S_R_VR      = 19'd1024,
        S_R_GAIN    = 19'd2048,
        S_R_LOOP    = 19'd4096,
        S_D_HDR     = 19'd8192,
        S_D_PK      = 19'd16384,
        S_D_F1      = 19'd32768,
        S_D_F2      = 19'd65536,
        S_R_MIX_SEL = 19'd131072,
        S_DONE      = 19'd262144
    } state_t;

    state_t state_reg, state_next;

    logic [VIDX_W-1:0] v_reg, v_next;
    logic [7:0]        mask_reg, mask_next;
    logic [7:0]        page_reg, page_next;
    logic [15:0]       ent_reg, ent_next;
    logic [7:0]        lo_reg, lo_next;
    logic [14:0]       ph_reg, ph_next;
    logic signed [7:0] gain_reg, gain_next;
    logic [7:0]        hdr_reg, hdr_next;
    logic signed [15:0] x_reg, x_next;
    logic signed [17:0] t1_reg, t1_next;
    logic signed [19:0] acc_reg, acc_next;
    logic              dir_keyon_reg, dir_keyon_next;
    logic              out_valid_reg, out_valid_next;
    logic signed [15:0] out_sample_reg, out_sample_next;

    logic [15:0]        blk_reg [VOICE_COUNT];
    logic [15:0]        blk_next [VOICE_COUNT];
    logic [3:0]         nib_reg [VOICE_COUNT];
    logic [3:0]         nib_next [VOICE_COUNT];
    logic [14:0]        phase_reg [VOICE_COUNT];
    logic [14:0]        phase_next [VOICE_COUNT];
    logic signed [15:0] h1_reg [VOICE_COUNT];
    logic signed [15:0] h1_next [VOICE_COUNT];
    logic signed [15:0] h2_reg [VOICE_COUNT];
    logic signed [15:0] h2_next [VOICE_COUNT];
    logic signed [15:0] held_reg [VOICE_COUNT];
    logic signed [15:0] held_next [VOICE_COUNT];
    logic [VOICE_COUNT-1:0] active_reg, active_next;

    brr_wr_t     wr;
    brr_rd_t     rd;
    logic [7:0]  mem_rdata;
    logic [7:0]  reg_rdata;
    logic        clear_busy;

    logic signed [15:0] mul_a;
    logic signed [7:0]  mul_k;
    logic [2:0]         mul_sh;
    logic signed [17:0] mul_res;

    logic               accept;
    logic               v_last;
    logic [6:0]         voice_base;
    logic [3:0]         nib4;
    logic signed [15:0] nib_ext;
    logic signed [15:0] nib_shl;
    logic signed [8:0]  gsum;
    logic signed [8:0]  gadj;
    logic signed [8:0]  gdiv;
    logic signed [19:0] dsum;
    logic signed [15:0] dsat;
    logic [15:0]        ent_calc;

    brr_avm_store u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr         (wr),
        .rd         (rd),
        .mem_rdata  (mem_rdata),
        .reg_rdata  (reg_rdata),
        .clear_busy (clear_busy)
    );

    brr_avm_mul u_mul (
        .a   (mul_a),
        .k   (mul_k),
        .sh  (mul_sh),
        .res (mul_res)
    );

    assign req.ready   = (state_reg == S_IDLE) && !clear_busy;
    assign accept      = req.valid && req.ready;
    assign rsp.valid   = out_valid_reg;
    assign rsp.payload.sample = out_sample_reg;

    assign v_last     = (v_reg == VIDX_W'(VOICE_COUNT - 1));
    assign voice_base = 7'(v_reg) << 4;

    always_comb
    begin
        wr.mem_we = accept && (req.payload.command == CMD_MEM_WR);
        wr.reg_we = accept && (req.payload.command == CMD_REG_WR);
        wr.addr   = req.payload.address;
        wr.data   = req.payload.data;
    end

    // Shared multiplier operands: filter taps during decode, volume during mixing.
    always_comb
    begin
        mul_a  = 16'sd0;
        mul_k  = 8'sd0;
        mul_sh = 3'd0;
        case (state_reg)
            S_D_F1:
            begin
                mul_a = h1_reg[v_reg];
                case (hdr_reg[3:2])
                    2'd1:
                    begin
                        mul_k  = 8'sd15;
                        mul_sh = 3'd4;
                    end
                    2'd2:
                    begin
                        mul_k  = 8'sd61;
                        mul_sh = 3'd5;
                    end
                    2'd3:
                    begin
                        mul_k  = 8'sd115;
                        mul_sh = 3'd6;
                    end
                    default:
                    begin
                        mul_k  = 8'sd0;
                        mul_sh = 3'd0;
                    end
                endcase
            end
            S_D_F2:
            begin
                mul_a  = h2_reg[v_reg];
                mul_sh = 3'd4;
                case (hdr_reg[3:2])
                    2'd2:    mul_k = 8'sd15;
                    2'd3:    mul_k = 8'sd13;
                    default: mul_k = 8'sd0;
                endcase
            end
            S_R_MIX_SEL:
            begin
                mul_a  = held_reg[v_reg];
                mul_k  = gain_reg;
                mul_sh = 3'd7;
            end
            default:
            begin
                mul_a  = 16'sd0;
            end
        endcase
    end

    always_comb
    begin
        nib4     = nib_reg[v_reg][0] ? mem_rdata[3:0] : mem_rdata[7:4];
        nib_ext  = 16'(signed'(nib4));
        nib_shl  = nib_ext <<< hdr_reg[7:4];
        gsum     = 9'(signed'(lo_reg)) + 9'(signed'(reg_rdata));
        gadj     = gsum + $signed({8'b0, gsum[8]});
        gdiv     = gadj >>> 1;
        dsum     = 20'(x_reg) + 20'(t1_reg) - 20'(mul_res);
        dsat     = sat16(dsum);
        ent_calc = {page_reg, 8'h00} + {6'b0, reg_rdata, 2'b00}
                 + {14'b0, (dir_keyon_reg ? 2'd0 : 2'd2)};
    end

    always_comb
    begin
        state_next      = state_reg;
        v_next          = v_reg;
        mask_next       = mask_reg;
        page_next       = page_reg;
        ent_next        = ent_reg;
        lo_next         = lo_reg;
        ph_next         = ph_reg;
        gain_next       = gain_reg;
        hdr_next        = hdr_reg;
        x_next          = x_reg;
        t1_next         = t1_reg;
        acc_next        = acc_reg;
        dir_keyon_next  = dir_keyon_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_sample_next = out_sample_reg;
        blk_next        = blk_reg;
        nib_next        = nib_reg;
        phase_next      = phase_reg;
        h1_next         = h1_reg;
        h2_next         = h2_reg;
        held_next       = held_reg;
        active_next     = active_reg;
        rd.mem_addr     = 16'h0000;
        rd.reg_addr     = 7'h00;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    v_next = '0;
                    if (req.payload.command == CMD_RENDER)
                    begin
                        acc_next   = 20'sd0;
                        state_next = S_R_PLO;
                    end
                    else if ((req.payload.command == CMD_REG_WR)
                             && (req.payload.address[6:0] == REG_KEY_ON))
                    begin
                        mask_next  = req.payload.data;
                        state_next = S_KEY_SCAN;
                    end
                end
            end
            S_KEY_SCAN:
            begin
                if (mask_reg[v_reg])
                begin
                    dir_keyon_next = 1'b1;
                    rd.reg_addr    = REG_DIR_PAGE;
                    state_next     = S_DIR_B;
                end
                else if (v_last)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    v_next = v_reg + 1'b1;
                end
            end
            S_DIR_A:
            begin
                rd.reg_addr = REG_DIR_PAGE;
                state_next  = S_DIR_B;
            end
            S_DIR_B:
            begin
                page_next   = reg_rdata;
                rd.reg_addr = voice_base | REG_SRCN;
                state_next  = S_DIR_C;
            end
            S_DIR_C:
            begin
                ent_next    = ent_calc;
                rd.mem_addr = ent_calc;
                state_next  = S_DIR_D;
            end
            S_DIR_D:
            begin
                lo_next     = mem_rdata;
                rd.mem_addr = ent_reg + 16'd1;
                state_next  = S_DIR_E;
            end
            S_DIR_E:
            begin
                blk_next[v_reg] = {mem_rdata, lo_reg};
                if (dir_keyon_reg)
                begin
                    nib_next[v_reg]    = 4'd0;
                    phase_next[v_reg]  = 15'd0;
                    h1_next[v_reg]     = 16'sd0;
                    h2_next[v_reg]     = 16'sd0;
                    held_next[v_reg]   = 16'sd0;
                    active_next[v_reg] = 1'b1;
                    if (v_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        v_next     = v_reg + 1'b1;
                        state_next = S_KEY_SCAN;
                    end
                end
                else
                begin
                    state_next = S_R_LOOP;
                end
            end
            S_R_PLO:
            begin
                rd.reg_addr = voice_base | REG_PITCH_LO;
                state_next  = S_R_PHI;
            end
            S_R_PHI:
            begin
                lo_next     = reg_rdata;
                rd.reg_addr = voice_base | REG_PITCH_HI;
                state_next  = S_R_VL;
            end
            S_R_VL:
            begin
                ph_next     = phase_reg[v_reg] + {1'b0, reg_rdata[5:0], lo_reg};
                rd.reg_addr = voice_base | REG_VOL_L;
                state_next  = S_R_VR;
            end
            S_R_VR:
            begin
                lo_next     = reg_rdata;
                rd.reg_addr = voice_base | REG_VOL_R;
                state_next  = S_R_GAIN;
            end
            S_R_GAIN:
            begin
                gain_next  = gdiv[7:0];
                state_next = S_R_LOOP;
            end
            S_R_LOOP:
            begin
                if (ph_reg >= PHASE_STEP)
                begin
                    ph_next = ph_reg - PHASE_STEP;
                    if (active_reg[v_reg])
                    begin
                        rd.mem_addr = blk_reg[v_reg];
                        state_next  = S_D_HDR;
                    end
                    else
                    begin
                        // A silent voice still steps and holds zero.
                        held_next[v_reg] = 16'sd0;
                    end
                end
                else
                begin
                    phase_next[v_reg] = ph_reg;
                    state_next        = S_R_MIX_SEL;
                end
            end
            S_D_HDR:
            begin
                hdr_next    = mem_rdata;
                rd.mem_addr = blk_reg[v_reg] + 16'd1 + {13'b0, nib_reg[v_reg][3:1]};
                state_next  = S_D_PK;
            end
            S_D_PK:
            begin
                if (hdr_reg[7:4] <= 4'd12)
                begin
                    x_next = nib_shl >>> 1;
                end
                else
                begin
                    x_next = nib4[3] ? -16'sd2048 : 16'sd0;
                end
                state_next = S_D_F1;
            end
            S_D_F1:
            begin
                t1_next    = mul_res;
                state_next = S_D_F2;
            end
            S_D_F2:
            begin
                h2_next[v_reg]   = h1_reg[v_reg];
                h1_next[v_reg]   = dsat;
                held_next[v_reg] = dsat;
                state_next       = S_R_LOOP;
                if (nib_reg[v_reg] == 4'd15)
                begin
                    nib_next[v_reg] = 4'd0;
                    if (hdr_reg[0])
                    begin
                        if (hdr_reg[1])
                        begin
                            dir_keyon_next = 1'b0;
                            state_next     = S_DIR_A;
                        end
                        else
                        begin
                            active_next[v_reg] = 1'b0;
                        end
                    end
                    else
                    begin
                        blk_next[v_reg] = blk_reg[v_reg] + 16'd9;
                    end
                end
                else
                begin
                    nib_next[v_reg] = nib_reg[v_reg] + 4'd1;
                end
            end
            S_R_MIX_SEL:
            begin
                acc_next = acc_reg + 20'(mul_res);
                if (v_last)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    v_next     = v_reg + 1'b1;
                    state_next = S_R_PLO;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_sample_next = sat16(acc_reg);
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            v_reg         <= '0;
            mask_reg      <= 8'h00;
            dir_keyon_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            active_reg    <= '0;
            for (int i = 0; i < VOICE_COUNT; i++)
            begin
                blk_reg[i]   <= 16'h0000;
                nib_reg[i]   <= 4'd0;
                phase_reg[i] <= 15'd0;
                h1_reg[i]    <= 16'sd0;
                h2_reg[i]    <= 16'sd0;
                held_reg[i]  <= 16'sd0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            v_reg         <= v_next;
            mask_reg      <= mask_next;
            dir_keyon_reg <= dir_keyon_next;
            out_valid_reg <= out_valid_next;
            active_reg    <= active_next;
            blk_reg       <= blk_next;
            nib_reg       <= nib_next;
            phase_reg     <= phase_next;
            h1_reg        <= h1_next;
            h2_reg        <= h2_next;
            held_reg      <= held_next;
        end
    end

    always_ff @(posedge clk)
    begin
        page_reg       <= page_next;
        ent_reg        <= ent_next;
        lo_reg         <= lo_next;
        ph_reg         <= ph_next;
        gain_reg       <= gain_next;
        hdr_reg        <= hdr_next;
        x_reg          <= x_next;
        t1_reg         <= t1_next;
        acc_reg        <= acc_next;
        out_sample_reg <= out_sample_next;
    end

    `BRR_AVM_ASSERT_IMP(a_no_accept_while_clearing, clk, rst_n, clear_busy, !req.ready,
        "word accepted during clearing pass")
    `BRR_AVM_ASSERT_IMP(a_decode_only_active, clk, rst_n, state_reg == S_D_HDR,
        active_reg[v_reg], "decode started on a silent voice")
    `BRR_AVM_ASSERT_IMP(a_phase_below_step, clk, rst_n, state_reg == S_R_MIX_SEL,
        ph_reg < PHASE_STEP, "phase left at or above one step")
    `BRR_AVM_ASSERT_NXT(a_done_waits, clk, rst_n,
        (state_reg == S_DONE) && out_valid_reg && !rsp.ready, state_reg == S_DONE,
        "result overwritten while stalled")

endmodule
`default_nettype wire

// File: rtl/brr_avm_store.sv
// Sample memory (64 KiB) and sound register file, with the clearing pass after reset.
// Depends on brr_avm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module brr_avm_store (
    input  wire                  clk,
    input  wire                  rst_n,
    input  brr_avm_pkg::brr_wr_t wr,
    input  brr_avm_pkg::brr_rd_t rd,
    output logic [7:0]           mem_rdata,
    output logic [7:0]           reg_rdata,
    output logic                 clear_busy
);
    import brr_avm_pkg::*;

    logic [7:0]  mem_array [0:65535];
    logic [7:0]  reg_array [0:127];
    logic [7:0]  mem_rdata_reg;
    logic [7:0]  reg_rdata_reg;
    logic [16:0] clr_cnt_reg;
    logic [16:0] clr_cnt_next;

    assign clear_busy   = !clr_cnt_reg[16];
    assign clr_cnt_next = clear_busy ? clr_cnt_reg + 17'd1 : clr_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else
        begin
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    // The clearing pass owns the write port until every byte has been zeroed.
    always_ff @(posedge clk)
    begin
        if (clear_busy)
        begin
            mem_array[clr_cnt_reg[15:0]] <= 8'h00;
            if (clr_cnt_reg[15:7] == 9'd0)
            begin
                reg_array[clr_cnt_reg[6:0]] <= 8'h00;
            end
        end
        else
        begin
            if (wr.mem_we)
            begin
                mem_array[wr.addr] <= wr.data;
            end
            if (wr.reg_we)
            begin
                reg_array[wr.addr[6:0]] <= wr.data;
            end
        end
        mem_rdata_reg <= mem_array[rd.mem_addr];
        reg_rdata_reg <= reg_array[rd.reg_addr];
    end

    assign mem_rdata = mem_rdata_reg;
    assign reg_rdata = reg_rdata_reg;

endmodule
`default_nettype wire

// File: rtl/brr_avm_mul.sv
// Shared multiply unit: signed product scaled down by a power of two, truncating toward zero.
// Depends on nothing; used by the top level for filters and mixing.
`timescale 1ns / 1ps
`default_nettype none
module brr_avm_mul (
    input  logic signed [15:0] a,
    input  logic signed [7:0]  k,
    input  logic [2:0]         sh,
    output logic signed [17:0] res
);
    logic signed [23:0] prod;
    logic signed [23:0] bias;
    logic signed [23:0] biased;
    logic signed [23:0] shifted;

    always_comb
    begin
        prod    = a * k;
        // A negative product is biased so that the arithmetic shift rounds toward zero.
        bias    = prod[23] ? ((24'sd1 <<< sh) - 24'sd1) : 24'sd0;
        biased  = prod + bias;
        shifted = biased >>> sh;
        res     = shifted[17:0];
    end

endmodule
`default_nettype wire
